/* design/supply_source_switch_selector_macros.svh */
// Assertion macros shared by the supply source switch selector RTL.
`ifndef SUPPLY_SOURCE_SWITCH_SELECTOR_MACROS_SVH
`define SUPPLY_SOURCE_SWITCH_SELECTOR_MACROS_SVH

// Same-cycle implication, checked on clk, muted while arst_n is low.
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, muted while arst_n is low.
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/sssel_pkg.sv */
// Types, codes and field widths for the supply source switch selector.
`default_nettype none

package sssel_pkg;

	localparam int unsigned CfgW   = 16;
	localparam int unsigned CntW   = 16;
	localparam int unsigned VdcW   = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned InTdataW  = 24;
	localparam int unsigned OutTdataW = 8;

	// Register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] CFG_COMMUT_DELAY      = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_COMMUT_DELAY_PACK = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_PACK_THRESHOLD    = 2'd2;

	localparam logic [CfgW-1:0] COMMUT_DELAY_RST      = 16'd100;
	localparam logic [CfgW-1:0] COMMUT_DELAY_PACK_RST = 16'd100;
	localparam logic [CfgW-1:0] PACK_THRESHOLD_RST    = 16'd0;

	typedef enum logic [1:0] {
		SRC_AC   = 2'd0,
		SRC_DC   = 2'd1,
		SRC_BAT  = 2'd2,
		SRC_TRAN = 2'd3
	} src_t;

	typedef struct packed {
		logic [CfgW-1:0] commut_delay;
		logic [CfgW-1:0] commut_delay_pack;
		logic [CfgW-1:0] pack_threshold;
	} cfg_t;

	typedef struct packed {
		logic            ac_loss;
		logic            dc_loss;
		logic            fail_vacdc;
		logic            fail_vdc;
		logic            dc_low;
		logic [VdcW-1:0] vdc_measure;
	} tick_t;

	typedef struct packed {
		src_t            supply;
		logic            armed;
		logic [CntW-1:0] countdown;
		logic            discharging;
	} sel_state_t;

	typedef struct packed {
		src_t switch_drive;
		logic discharge_flag;
		logic battery_idle_pulse;
		logic commit_pulse;
	} result_t;

endpackage

`default_nettype wire

/* design/sssel_decide.sv */
// Per-tick source selection and countdown next-state logic.
`default_nettype none

module sssel_decide (
	input  sssel_pkg::cfg_t       cfg,
	input  sssel_pkg::tick_t      tick,
	input  sssel_pkg::sel_state_t cur,
	output sssel_pkg::sel_state_t nxt,
	output sssel_pkg::result_t    res
);

	sssel_pkg::src_t                 target;
	logic                            hold;
	logic [sssel_pkg::CntW-1:0]      len;
	logic                            arm;
	logic [sssel_pkg::CntW-1:0]      cnt_a;
	logic                            cnt_zero;
	logic                            commit;
	sssel_pkg::src_t                 src_b;

	// Priority: AC, held AC on a failed reading, DC, held DC, battery
	always_comb begin
		hold   = 1'b0;
		len    = cfg.commut_delay;
		target = sssel_pkg::SRC_BAT;
		priority if (!tick.ac_loss && !tick.fail_vacdc) begin
			target = sssel_pkg::SRC_AC;
		end else if (tick.fail_vacdc && !tick.ac_loss && cur.supply == sssel_pkg::SRC_AC) begin
			target = sssel_pkg::SRC_AC;
			hold   = 1'b1;
		end else if (!tick.dc_low && !tick.dc_loss && !tick.fail_vdc) begin
			target = sssel_pkg::SRC_DC;
			if (tick.vdc_measure >= cfg.pack_threshold) begin
				len = cfg.commut_delay_pack;
			end
		end else if (tick.fail_vdc && !tick.dc_loss && cur.supply == sssel_pkg::SRC_DC) begin
			target = sssel_pkg::SRC_DC;
			hold   = 1'b1;
		end else begin
			target = sssel_pkg::SRC_BAT;
		end
	end

	assign arm      = !hold && (cur.supply != target) && !cur.armed;
	assign cnt_a    = arm ? len : cur.countdown;
	assign cnt_zero = (cnt_a == '0);
	assign commit   = !hold && (cur.supply != target) && cnt_zero;
	assign src_b    = commit ? target : cur.supply;

	always_comb begin
		nxt.discharging = commit ? (target == sssel_pkg::SRC_BAT) : cur.discharging;
		if (cnt_zero) begin
			nxt.supply    = src_b;
			nxt.armed     = 1'b0;
			nxt.countdown = '0;
		end else begin
			nxt.supply    = sssel_pkg::SRC_TRAN;
			nxt.armed     = 1'b1;
			nxt.countdown = cnt_a - 1'b1;
		end
		res.switch_drive       = nxt.supply;
		res.discharge_flag     = nxt.discharging;
		res.battery_idle_pulse = commit && (target != sssel_pkg::SRC_BAT);
		res.commit_pulse       = commit;
	end

endmodule

`default_nettype wire

/* design/supply_source_switch_selector.sv */
// Top level of the supply source switch selector: config, state and result registers.
//
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    s_tdata: flags and DC voltage of one tick
//  m_axis    out  m_tvalid/m_tready    m_tdata: drive code, discharge and pulses
//  cfg       in   cfg_we               cfg_index, cfg_data (16 bit)
//
// One tick per cycle while the result register drains; a result shows in the cycle after its input transfer.
// The decision is a single pass from the state registers to the result register.
// s_tready drops only while a result waits and m_tready is low.
// arst_n clears config to defaults, state to transition with no countdown.
// Config writes land at the clock edge with cfg_we high; index 3 is ignored.
`default_nettype none
`include "supply_source_switch_selector_macros.svh"

module supply_source_switch_selector (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// s_tdata: ac_loss, dc_loss, fail_vacdc, fail_vdc, dc_low, vdc_measure[15:0], pad
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [sssel_pkg::InTdataW-1:0]        s_tdata,
	// m_tdata: switch_drive[1:0], discharge_flag, battery_idle_pulse, commit_pulse, pad
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [sssel_pkg::OutTdataW-1:0]            m_tdata,
	input  wire logic                                  cfg_we,
	input  wire logic [sssel_pkg::CfgIdxW-1:0]         cfg_index,
	input  wire logic [sssel_pkg::CfgW-1:0]            cfg_data
);

	sssel_pkg::cfg_t       cfg_q;
	sssel_pkg::sel_state_t state_q;
	sssel_pkg::sel_state_t state_nxt;
	sssel_pkg::tick_t      tick;
	sssel_pkg::result_t    res;
	sssel_pkg::result_t    res_q;
	logic                  m_valid_q;
	logic                  s_xfer;

	// unpack the input transfer, lowest field first
	assign tick.ac_loss     = s_tdata[0];
	assign tick.dc_loss     = s_tdata[1];
	assign tick.fail_vacdc  = s_tdata[2];
	assign tick.fail_vdc    = s_tdata[3];
	assign tick.dc_low      = s_tdata[4];
	assign tick.vdc_measure = s_tdata[20:5];

	// result register empties or drains this cycle -> take a new tick
	assign s_tready = !m_valid_q || m_tready;
	assign s_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.commut_delay      <= sssel_pkg::COMMUT_DELAY_RST;
			cfg_q.commut_delay_pack <= sssel_pkg::COMMUT_DELAY_PACK_RST;
			cfg_q.pack_threshold    <= sssel_pkg::PACK_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sssel_pkg::CFG_COMMUT_DELAY:      cfg_q.commut_delay      <= cfg_data;
				sssel_pkg::CFG_COMMUT_DELAY_PACK: cfg_q.commut_delay_pack <= cfg_data;
				sssel_pkg::CFG_PACK_THRESHOLD:    cfg_q.pack_threshold    <= cfg_data;
				default: ;
			endcase
		end
	end

	sssel_decide u_decide (
		.cfg  (cfg_q),
		.tick (tick),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	// selector state advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.supply      <= sssel_pkg::SRC_TRAN;
			state_q.armed       <= 1'b0;
			state_q.countdown   <= '0;
			state_q.discharging <= 1'b0;
		end else if (s_xfer) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_xfer) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, res_q.commit_pulse, res_q.battery_idle_pulse,
		res_q.discharge_flag, res_q.switch_drive};

	// a running countdown always shows as transition and keeps the timer armed
	`SSS_ASSERT_NOW(a_cnt_tran, state_q.countdown != '0, state_q.supply == sssel_pkg::SRC_TRAN, "countdown running outside transition")
	`SSS_ASSERT_NOW(a_cnt_armed, state_q.countdown != '0, state_q.armed, "countdown running with timer disarmed")
	// a commit always drives a real source
	`SSS_ASSERT_NOW(a_commit_drive, m_valid_q && res_q.commit_pulse, res_q.switch_drive != sssel_pkg::SRC_TRAN, "commit reported during transition")
	// battery idle only comes with a commit to AC or DC
	`SSS_ASSERT_NOW(a_idle_commit, m_valid_q && res_q.battery_idle_pulse, res_q.commit_pulse && !res_q.discharge_flag, "idle pulse without commit")
	// state moves only on an input transfer
	`SSS_ASSERT_NEXT(a_state_hold, !s_xfer, $stable(state_q), "state changed without a transfer")

endmodule

`default_nettype wire
